>>> rtl/ps2_scancode_decoder_defines.svh
// Assertion macros for the PS/2 scan code decoder.
`ifndef PS2_SCANCODE_DECODER_DEFINES_SVH
`define PS2_SCANCODE_DECODER_DEFINES_SVH

`ifndef SYNTH
`define PS2SD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ps2 decoder: same-cycle check failed");
`define PS2SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ps2 decoder: next-cycle check failed");
`else
`define PS2SD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PS2SD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/ps2sd_pkg.sv
package ps2sd_pkg;

  // item operations
  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_FOCUS = 2'd2;

  // translation tables
  localparam logic [1:0] TBL_UNSHIFTED = 2'd0;
  localparam logic [1:0] TBL_SHIFTED   = 2'd1;
  localparam logic [1:0] TBL_CONTROL   = 2'd2;
  localparam logic [1:0] TBL_EXTENDED  = 2'd3;

  // scan codes, set 2
  localparam logic [7:0] CODE_RELEASE = 8'hF0;
  localparam logic [7:0] CODE_EXTEND  = 8'hE0;
  localparam logic [7:0] CODE_CTRL    = 8'h14;
  localparam logic [7:0] CODE_RSHIFT  = 8'h59;
  localparam logic [7:0] CODE_NUMLOCK = 8'h77;
  localparam logic [7:0] CODE_SCROLL  = 8'h7E;
  localparam logic [7:0] CODE_CAPS    = 8'h58;
  localparam logic [7:0] CODE_ALT     = 8'h11;
  localparam logic [7:0] CODE_TAB     = 8'h0D;

  // modifier byte bit positions
  localparam int unsigned MOD_SHIFT  = 0;
  localparam int unsigned MOD_ALT    = 1;
  localparam int unsigned MOD_CTRL   = 2;
  localparam int unsigned MOD_NUM    = 4;
  localparam int unsigned MOD_CAPS   = 5;
  localparam int unsigned MOD_SCROLL = 6;
  localparam int unsigned MOD_EXT    = 7;

  localparam int unsigned TBL_ADDR_W = 10;

  typedef struct packed {
    logic       rel_flag;
    logic [7:0] mod_state;
  } key_state_t;

  typedef struct packed {
    key_state_t state;
    logic [1:0] kind;
    logic [1:0] tbl;
  } dec_result_t;

endpackage

>>> rtl/ps2_scancode_decoder.sv
// PS/2 set 2 scan code decoder. Each input transfer carries either a scan code
// to decode or one table write (index, table, byte); every input transfer gives
// exactly one output transfer reporting the result kind, the translated
// character, and the modifier byte and release flag as they stand after that
// item. One item per clock is sustained while m_tready stays high; each result
// passes the input register, then the result stage that updates the key state
// and reads the translation memory, whose registered read data is the result.
// The four translation tables share one 1024 x 8 memory with one write and one
// read port, which is never cleared: decode only codes whose table entries have
// been written. Output back-pressure stalls the input register, which keeps one
// item while a result waits.
`include "ps2_scancode_decoder_defines.svh"

module ps2_scancode_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // [7:0] scan_code, [9:8] table_sel, [17:10] table_data
  input  logic        s_tuser,  // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // [7:0] char_out, [15:8] modifier_bits, [16] release_pending
  output logic [1:0]  m_tuser   // [1:0] result_kind
);

  // input register
  logic       s0_valid;
  logic       s0_op;
  logic [7:0] s0_code;
  logic [1:0] s0_sel;
  logic [7:0] s0_data;

  // key state and result register
  ps2sd_pkg::key_state_t  key_state;
  ps2sd_pkg::dec_result_t dec;
  logic [1:0]             out_kind;
  logic [7:0]             rd_data;

  logic in_xfer;
  logic adv;   // input register moves into the result register

  assign adv      = s0_valid && (!m_tvalid || m_tready);
  assign s_tready = !s0_valid || adv;
  assign in_xfer  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_xfer) begin
      s0_valid <= 1'b1;
    end else if (adv) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s0_op   <= s_tuser;
      s0_code <= s_tdata[7:0];
      s0_sel  <= s_tdata[9:8];
      s0_data <= s_tdata[17:10];
    end
  end

  ps2sd_decode u_decode (
    .opcode    (s0_op),
    .scan_code (s0_code),
    .cur       (key_state),
    .res       (dec)
  );

  // writes use the item's table; decodes use the table picked from the modifiers
  ps2sd_table_ram u_table_ram (
    .clk     (clk),
    .wr_en   (adv && s0_op == ps2sd_pkg::OP_WRITE),
    .wr_addr ({s0_sel, s0_code}),
    .wr_data (s0_data),
    .rd_en   (adv),
    .rd_addr ({dec.tbl, s0_code}),
    .rd_data (rd_data)
  );

  // key state only moves together with the result register, so it always
  // matches the result on show
  always_ff @(posedge clk) begin
    if (rst) begin
      key_state <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (adv) begin
        key_state <= dec.state;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_kind <= dec.kind;
    end
  end

  assign m_tuser = out_kind;
  assign m_tdata = {7'd0, key_state.rel_flag, key_state.mod_state,
                    (out_kind == ps2sd_pkg::KIND_CHAR) ? rd_data : 8'd0};

  // table writes leave the key state untouched
  `PS2SD_ASSERT_NEXT(a_write_keeps_state, clk, rst, adv && s0_op == ps2sd_pkg::OP_WRITE, $stable(key_state))
  // an extended translation consumes the extended prefix
  `PS2SD_ASSERT_NEXT(a_ext_cleared, clk, rst, adv && dec.kind == ps2sd_pkg::KIND_CHAR && dec.tbl == ps2sd_pkg::TBL_EXTENDED, !key_state.mod_state[ps2sd_pkg::MOD_EXT])
  // a held item in the input register is never dropped
  `PS2SD_ASSERT_NEXT(a_s0_held, clk, rst, s0_valid && !adv, s0_valid && $stable(s0_code))
  // modifier bit 3 is unused
  `PS2SD_ASSERT_IMPL(a_mod_bit3_zero, clk, rst, m_tvalid, !key_state.mod_state[3])

endmodule

>>> rtl/ps2sd_decode.sv
// Next key state, result kind and table choice for one item.
module ps2sd_decode (
  input  logic                 opcode,
  input  logic [7:0]           scan_code,
  input  ps2sd_pkg::key_state_t cur,
  output ps2sd_pkg::dec_result_t res
);

  always_comb begin
    res.state = cur;
    res.kind  = ps2sd_pkg::KIND_NONE;
    res.tbl   = ps2sd_pkg::TBL_UNSHIFTED;
    if (opcode == ps2sd_pkg::OP_DECODE) begin
      case (scan_code)
        ps2sd_pkg::CODE_RELEASE: begin
          res.state.rel_flag = 1'b1;
        end
        ps2sd_pkg::CODE_EXTEND: begin
          res.state.mod_state[ps2sd_pkg::MOD_EXT] = 1'b1;
        end
        ps2sd_pkg::CODE_CTRL: begin
          res.state.mod_state[ps2sd_pkg::MOD_CTRL] = ~cur.rel_flag;
          res.state.rel_flag = 1'b0;
        end
        ps2sd_pkg::CODE_RSHIFT: begin
          res.state.mod_state[ps2sd_pkg::MOD_SHIFT] = ~cur.rel_flag;
          res.state.rel_flag = 1'b0;
        end
        ps2sd_pkg::CODE_ALT: begin
          res.state.mod_state[ps2sd_pkg::MOD_ALT] = ~cur.rel_flag;
          res.state.rel_flag = 1'b0;
        end
        // lock keys toggle and leave a pending release alone
        ps2sd_pkg::CODE_NUMLOCK: begin
          res.state.mod_state[ps2sd_pkg::MOD_NUM] = ~cur.mod_state[ps2sd_pkg::MOD_NUM];
        end
        ps2sd_pkg::CODE_CAPS: begin
          res.state.mod_state[ps2sd_pkg::MOD_CAPS] = ~cur.mod_state[ps2sd_pkg::MOD_CAPS];
        end
        ps2sd_pkg::CODE_SCROLL: begin
          res.state.mod_state[ps2sd_pkg::MOD_SCROLL] =
            ~cur.mod_state[ps2sd_pkg::MOD_SCROLL];
        end
        default: begin
          if (scan_code == ps2sd_pkg::CODE_TAB && cur.mod_state[ps2sd_pkg::MOD_ALT] &&
              !cur.rel_flag) begin
            res.kind = ps2sd_pkg::KIND_FOCUS;
          end else if (cur.rel_flag) begin
            // ordinary release: extended bit is kept
            res.state.rel_flag = 1'b0;
          end else begin
            res.kind = ps2sd_pkg::KIND_CHAR;
            if (cur.mod_state[ps2sd_pkg::MOD_EXT]) begin
              res.state.mod_state[ps2sd_pkg::MOD_EXT] = 1'b0;
              res.tbl = ps2sd_pkg::TBL_EXTENDED;
            end else if (cur.mod_state[ps2sd_pkg::MOD_CTRL]) begin
              res.tbl = ps2sd_pkg::TBL_CONTROL;
            end else if (cur.mod_state[ps2sd_pkg::MOD_SHIFT]) begin
              res.tbl = ps2sd_pkg::TBL_SHIFTED;
            end else begin
              res.tbl = ps2sd_pkg::TBL_UNSHIFTED;
            end
          end
        end
      endcase
    end
  end

endmodule

>>> rtl/ps2sd_table_ram.sv
// Four 256-entry translation tables in one memory; registered read with enable.
module ps2sd_table_ram (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [ps2sd_pkg::TBL_ADDR_W-1:0] wr_addr,
  input  logic [7:0]                       wr_data,
  input  logic                             rd_en,
  input  logic [ps2sd_pkg::TBL_ADDR_W-1:0] rd_addr,
  output logic [7:0]                       rd_data
);

  logic [7:0] mem [2**ps2sd_pkg::TBL_ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
